[sv/rprf_pkg.sv]
// Shared types and constants for the recent pair repeat filter.
`default_nettype none

package rprf_pkg;

	localparam int HISTORY_DEPTH = 64;
	localparam int SLOT_W        = $clog2(HISTORY_DEPTH);
	localparam int COUNT_W       = $clog2(HISTORY_DEPTH + 1);
	localparam int WORD_W        = 32;
	localparam int WORDS         = 4;
	localparam int PAIR_W        = WORD_W * WORDS;
	localparam int DEPTH_W       = 7;

	typedef enum logic [1:0] {
		STATUS_NEW        = 2'd0,
		STATUS_REPEAT     = 2'd1,
		STATUS_NO_HISTORY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_FINISH
	} state_t;

	// IEEE equality on single-precision bit patterns
	function automatic logic float_eq(input logic [WORD_W-1:0] a, input logic [WORD_W-1:0] b);
		logic nan_a;
		logic nan_b;
		nan_a = a[WORD_W-2:0] > 31'h7F80_0000;
		nan_b = b[WORD_W-2:0] > 31'h7F80_0000;
		float_eq = !nan_a && !nan_b &&
			(((a[WORD_W-2:0] | b[WORD_W-2:0]) == '0) || (a == b));
	endfunction

endpackage

`default_nettype wire

[sv/rprf_store.sv]
// Pair history memory: one write port, one registered read port.
`default_nettype none

module rprf_store
	import rprf_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              rd_en,
	input  wire logic [SLOT_W-1:0] rd_addr,
	output logic      [PAIR_W-1:0] rd_data,
	input  wire logic              wr_en,
	input  wire logic [SLOT_W-1:0] wr_addr,
	input  wire logic [PAIR_W-1:0] wr_data
);

	logic [PAIR_W-1:0] mem [HISTORY_DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

[sv/recent_pair_repeat_filter.sv]
// Top level of the recent pair repeat filter: control sequencer around the pair memory.
`default_nettype none

// Each item is a pair of 2-D points given as four single-precision bit
// patterns. The block searches every pair it holds (up to history_depth, at
// most 64; larger settings act as 64) and returns status 1 on a match, where
// matching is IEEE equality per word (+0 equals -0, NaN equals nothing).
// Otherwise the pair goes into a ring, replacing the oldest entry once the
// ring is full, and status 0 is returned. With history_depth zero every item
// gets status 2 and nothing is stored. Writing history_depth empties the
// history; write it only while no item is in flight (cfg_ready is high only
// then). One item is worked on at a time: the search reads one stored pair
// per cycle from the history memory and compares it the cycle after. A repeat
// ends the search at the matching entry. The result sits in an output register,
// so the next item is taken while the previous result waits on result_stall.

module recent_pair_repeat_filter
	import rprf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	// configuration write (history_depth)
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [DEPTH_W-1:0] cfg_data,
	// input item
	input  wire logic               item_valid,
	output logic                    item_stall,
	input  wire logic [WORD_W-1:0]  first_x,
	input  wire logic [WORD_W-1:0]  first_y,
	input  wire logic [WORD_W-1:0]  second_x,
	input  wire logic [WORD_W-1:0]  second_y,
	// result
	output logic                    result_valid,
	input  wire logic               result_stall,
	output logic [1:0]              status
);

	state_t state_q, state_d;

	logic [DEPTH_W-1:0] depth_q;
	logic [COUNT_W-1:0] eff_depth;
	logic [SLOT_W-1:0]  slot_q;
	logic [COUNT_W-1:0] filled_q;
	logic [COUNT_W-1:0] slot_inc;

	logic [PAIR_W-1:0]  pair_q;
	status_t            pend_q;
	logic [COUNT_W-1:0] rd_idx_q;
	logic               cmp_valid_s1;
	logic [PAIR_W-1:0]  rd_data_s1;

	logic    out_valid_q;
	status_t out_status_q;

	logic item_take;
	logic cfg_take;
	logic rd_en;
	logic match;
	logic hit;
	logic scan_done;
	logic out_free;
	logic finish;
	logic wr_en;

	// depth settings above capacity act as full capacity
	assign eff_depth = (depth_q > DEPTH_W'(HISTORY_DEPTH))
		? COUNT_W'(HISTORY_DEPTH) : COUNT_W'(depth_q);

	assign cfg_ready    = (state_q == ST_IDLE);
	assign cfg_take     = cfg_valid && cfg_ready;
	assign item_stall   = (state_q != ST_IDLE);
	assign item_take    = item_valid && !item_stall;
	assign result_valid = out_valid_q;
	assign status       = out_status_q;

	// all four words must match
	always_comb begin
		match = 1'b1;
		for (int k = 0; k < WORDS; k++) begin
			if (!float_eq(rd_data_s1[k*WORD_W +: WORD_W], pair_q[k*WORD_W +: WORD_W])) begin
				match = 1'b0;
			end
		end
	end

	assign hit       = cmp_valid_s1 && match;
	assign rd_en     = (state_q == ST_SCAN) && (rd_idx_q < filled_q) && !hit;
	assign scan_done = !rd_en && !cmp_valid_s1;
	assign out_free  = !out_valid_q || !result_stall;
	assign finish    = (state_q == ST_FINISH) && out_free;
	assign wr_en     = finish && (pend_q == STATUS_NEW);
	assign slot_inc  = COUNT_W'(slot_q) + COUNT_W'(1);

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (item_take) begin
					state_d = (eff_depth == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				if (hit || scan_done) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// control state: config, ring pointers, scan counter, output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q      <= '0;
			slot_q       <= '0;
			filled_q     <= '0;
			rd_idx_q     <= '0;
			cmp_valid_s1 <= 1'b0;
			pend_q       <= STATUS_NEW;
			out_valid_q  <= 1'b0;
			out_status_q <= STATUS_NEW;
		end else begin
			cmp_valid_s1 <= rd_en;
			if (cfg_take) begin
				depth_q  <= cfg_data;
				slot_q   <= '0;
				filled_q <= '0;
			end
			if (item_take) begin
				rd_idx_q <= '0;
				pend_q   <= (eff_depth == '0) ? STATUS_NO_HISTORY : STATUS_NEW;
			end
			if (rd_en) begin
				rd_idx_q <= rd_idx_q + COUNT_W'(1);
			end
			if ((state_q == ST_SCAN) && hit) begin
				pend_q <= STATUS_REPEAT;
			end
			if (out_valid_q && !result_stall) begin
				out_valid_q <= 1'b0;
			end
			if (finish) begin
				out_valid_q  <= 1'b1;
				out_status_q <= pend_q;
			end
			if (wr_en) begin
				slot_q <= (slot_inc >= eff_depth) ? '0 : slot_inc[SLOT_W-1:0];
				if (filled_q < eff_depth) begin
					filled_q <= filled_q + COUNT_W'(1);
				end
			end
		end
	end

	// item payload, held for the whole search
	always_ff @(posedge clk) begin
		if (item_take) begin
			pair_q <= {second_y, second_x, first_y, first_x};
		end
	end

	rprf_store u_store (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (rd_idx_q[SLOT_W-1:0]),
		.rd_data (rd_data_s1),
		.wr_en   (wr_en),
		.wr_addr (slot_q),
		.wr_data (pair_q)
	);

endmodule

`default_nettype wire
